/* rtl/prpz_pkg.sv */
package prpz_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] point_x;
        logic [7:0] point_y;
        logic [7:0] point_z;
        logic [2:0] point_color;
        logic [7:0] read_column;
        logic [6:0] read_row;
    } req_t;

    typedef struct packed {
        logic       plotted;
        logic [2:0] pixel_color;
        logic [7:0] pixel_glyph;
    } rsp_t;

    typedef struct packed {
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_pitch;
        logic signed [15:0] sin_pitch;
    } rot_t;

    typedef struct packed {
        req_t req;
        logic rd_hit;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_YAW,
        ST_SUM1,
        ST_PITCH,
        ST_SUM2,
        ST_SCALE,
        ST_TEST,
        ST_DIV,
        ST_INDEX,
        ST_RREQ,
        ST_RCHK,
        ST_PUSH
    } back_state_t;

    localparam logic REQ_PLOT = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] REG_COS_YAW   = 2'd0;
    localparam logic [1:0] REG_SIN_YAW   = 2'd1;
    localparam logic [1:0] REG_COS_PITCH = 2'd2;
    localparam logic [1:0] REG_SIN_PITCH = 2'd3;

    localparam int COLOR_W = 3;
    localparam int DEPTH_W = 18;
    localparam int WORD_W  = COLOR_W + DEPTH_W;

    localparam logic [DEPTH_W-1:0] DEPTH_FAR = 18'd131071;
    localparam logic [COLOR_W-1:0] COLOR_BG  = 3'd0;
    localparam logic [7:0]         GLYPH_BG  = 8'd32;

    localparam logic [2:0] DIV_LAST = 3'd6;

    function automatic logic [7:0] glyph_of(input logic [2:0] c);
        logic [7:0] g;
        case (c)
            3'd0:    g = 8'd32;
            3'd1:    g = 8'd46;
            3'd2:    g = 8'd42;
            3'd3:    g = 8'd176;
            3'd4:    g = 8'd177;
            default: g = 8'd219;
        endcase
        return g;
    endfunction

endpackage

/* rtl/prpz_ram.sv */
module prpz_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 14400
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* rtl/prpz_fifo.sv */
module prpz_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [PW:0]      count_reg;
    logic             wr, rd;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

/* rtl/prpz_front.sv */
module prpz_front #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 90
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  prpz_pkg::req_t req,
    input  logic          push,
    output logic          full,
    output prpz_pkg::cmd_t cmd,
    output logic          cmd_empty,
    input  logic          cmd_pop
);

    prpz_pkg::cmd_t cmd_in;
    logic           q_full;

    assign full = q_full || hold;

    // classify reads that fall off the window here, so the back skips the store
    always_comb
    begin
        cmd_in.req    = req;
        cmd_in.rd_hit = (32'(req.read_column) < SCREEN_WIDTH)
                     && (32'(req.read_row) < SCREEN_HEIGHT);
    end

    prpz_fifo #(
        .WIDTH($bits(prpz_pkg::cmd_t)),
        .DEPTH(2)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push && !hold),
        .din  (cmd_in),
        .full (q_full),
        .pop  (cmd_pop),
        .dout (cmd),
        .empty(cmd_empty)
    );

endmodule

/* rtl/prpz_back.sv */
module prpz_back #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 90
) (
    input  logic           clk,
    input  logic           rst_n,
    input  prpz_pkg::rot_t rot,
    input  prpz_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output prpz_pkg::rsp_t res,
    output logic           res_push,
    input  logic           res_full,
    output logic           clearing
);

    localparam int PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW        = $clog2(PIXELS);
    localparam int DEPTH_W_L = prpz_pkg::DEPTH_W;

    prpz_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]         addr_reg, addr_next;
    prpz_pkg::rsp_t        res_reg, res_next;
    prpz_pkg::cmd_t        cmd_reg;
    logic [2:0]            cnt_reg;

    logic signed [24:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [15:0] a_reg, b_reg;
    logic signed [28:0] p1_reg, p3_reg;
    logic signed [31:0] p2_reg, p4_reg;
    logic signed [20:0] z2_reg, y2_reg;
    logic signed [31:0] nx_reg, ny_reg, zx_reg, zn_reg, zp_reg;
    logic [30:0]        remx_reg, remy_reg;
    logic [25:0]        ds_reg;
    logic [6:0]         qx_reg, qy_reg;
    logic               sx_reg, sy_reg;

    logic signed [8:0]  dx, dz;
    logic signed [12:0] dy;
    logic signed [25:0] asum, bsum;
    logic signed [33:0] zsum, ysum;
    logic signed [17:0] xc;
    logic signed [21:0] yc;
    logic               keep;
    logic [8:0]         colv, rowv;
    logic               bit_x, bit_y;
    logic [DEPTH_W_L-1:0] zd;

    logic                          ram_we, ram_re;
    logic [prpz_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;
    logic [prpz_pkg::COLOR_W-1:0]  st_color;
    logic [prpz_pkg::DEPTH_W-1:0]  st_depth;

    assign clearing = (state_reg == prpz_pkg::ST_CLEAR);
    assign res      = res_reg;

    assign dx = $signed({1'b0, cmd_reg.req.point_x}) - 9'sd10;
    assign dz = $signed({1'b0, cmd_reg.req.point_z}) - 9'sd160;
    assign dy = $signed({1'b0, cmd_reg.req.point_y, 4'b0000}) - 13'sd800;

    assign asum = pa_reg + pb_reg;
    assign bsum = pc_reg - pd_reg;
    assign zsum = p1_reg + p2_reg;
    assign ysum = 34'sd0 - p3_reg - p4_reg;
    assign xc   = a_reg + 18'sd160 - 18'sd800;
    assign yc   = y2_reg - 22'sd800;

    assign keep = (z2_reg > 21'sd0) && (nx_reg > -zx_reg) && (nx_reg < zx_reg)
               && (ny_reg > -zn_reg) && (ny_reg < zp_reg);

    assign bit_x = ({5'b0, remx_reg} >= {10'b0, ds_reg});
    assign bit_y = ({5'b0, remy_reg} >= {10'b0, ds_reg});

    assign colv = sx_reg ? (9'd80 - {2'b00, qx_reg}) : (9'd80 + {2'b00, qx_reg});
    assign rowv = sy_reg ? (9'd40 - {2'b00, qy_reg}) : (9'd40 + {2'b00, qy_reg});

    // saturate depth at DEPTH_FAR, the far depth the store is cleared to
    assign zd = (z2_reg > 21'sd131071) ? prpz_pkg::DEPTH_FAR : z2_reg[DEPTH_W_L-1:0];

    assign st_color = ram_rdata[prpz_pkg::WORD_W-1 -: prpz_pkg::COLOR_W];
    assign st_depth = ram_rdata[prpz_pkg::DEPTH_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        res_next   = res_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wdata  = {prpz_pkg::COLOR_BG, prpz_pkg::DEPTH_FAR};
        case (state_reg)
            prpz_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(PIXELS - 1))
                begin
                    state_next = prpz_pkg::ST_IDLE;
                end
            end
            prpz_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.req.req_type == prpz_pkg::REQ_READ)
                    begin
                        addr_next = AW'(32'(cmd.req.read_row) * SCREEN_WIDTH
                                        + 32'(cmd.req.read_column));
                        if (cmd.rd_hit)
                        begin
                            state_next = prpz_pkg::ST_RREQ;
                        end
                        else
                        begin
                            res_next   = '{plotted: 1'b0, pixel_color: prpz_pkg::COLOR_BG,
                                           pixel_glyph: prpz_pkg::GLYPH_BG};
                            state_next = prpz_pkg::ST_PUSH;
                        end
                    end
                    else
                    begin
                        state_next = prpz_pkg::ST_YAW;
                    end
                end
            end
            prpz_pkg::ST_YAW:   state_next = prpz_pkg::ST_SUM1;
            prpz_pkg::ST_SUM1:  state_next = prpz_pkg::ST_PITCH;
            prpz_pkg::ST_PITCH: state_next = prpz_pkg::ST_SUM2;
            prpz_pkg::ST_SUM2:  state_next = prpz_pkg::ST_SCALE;
            prpz_pkg::ST_SCALE: state_next = prpz_pkg::ST_TEST;
            prpz_pkg::ST_TEST:
            begin
                res_next = '0;
                if (keep)
                begin
                    state_next = prpz_pkg::ST_DIV;
                end
                else
                begin
                    state_next = prpz_pkg::ST_PUSH;
                end
            end
            prpz_pkg::ST_DIV:
            begin
                if (cnt_reg == prpz_pkg::DIV_LAST)
                begin
                    state_next = prpz_pkg::ST_INDEX;
                end
            end
            prpz_pkg::ST_INDEX:
            begin
                addr_next = AW'(32'(rowv) * SCREEN_WIDTH + 32'(colv));
                if ((32'(colv) < SCREEN_WIDTH) && (32'(rowv) < SCREEN_HEIGHT))
                begin
                    state_next = prpz_pkg::ST_RREQ;
                end
                else
                begin
                    state_next = prpz_pkg::ST_PUSH;
                end
            end
            prpz_pkg::ST_RREQ:
            begin
                ram_re     = 1'b1;
                state_next = prpz_pkg::ST_RCHK;
            end
            prpz_pkg::ST_RCHK:
            begin
                if (cmd_reg.req.req_type == prpz_pkg::REQ_READ)
                begin
                    ram_we   = 1'b1;
                    res_next = '{plotted: 1'b0, pixel_color: st_color,
                                 pixel_glyph: prpz_pkg::glyph_of(st_color)};
                end
                else if (st_depth > zd)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {cmd_reg.req.point_color, zd};
                    res_next  = '{plotted: 1'b1, pixel_color: prpz_pkg::COLOR_BG,
                                  pixel_glyph: 8'd0};
                end
                state_next = prpz_pkg::ST_PUSH;
            end
            prpz_pkg::ST_PUSH:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = prpz_pkg::ST_IDLE;
                end
            end
            default: state_next = prpz_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prpz_pkg::ST_CLEAR;
            addr_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (state_reg == prpz_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == prpz_pkg::ST_YAW)
        begin
            pa_reg <= dx * rot.cos_yaw;
            pb_reg <= dz * rot.sin_yaw;
            pc_reg <= dz * rot.cos_yaw;
            pd_reg <= dx * rot.sin_yaw;
        end
        if (state_reg == prpz_pkg::ST_SUM1)
        begin
            a_reg <= asum[25:10];
            b_reg <= bsum[25:10];
        end
        if (state_reg == prpz_pkg::ST_PITCH)
        begin
            p1_reg <= dy * rot.sin_pitch;
            p2_reg <= b_reg * rot.cos_pitch;
            p3_reg <= dy * rot.cos_pitch;
            p4_reg <= b_reg * rot.sin_pitch;
        end
        if (state_reg == prpz_pkg::ST_SUM2)
        begin
            z2_reg <= $signed(zsum[33:14]) + 21'sd2560;
            y2_reg <= $signed(ysum[33:14]) + 21'sd800;
        end
        if (state_reg == prpz_pkg::ST_SCALE)
        begin
            nx_reg <= xc * 32'sd120;
            ny_reg <= yc * 32'sd120;
            zx_reg <= z2_reg * 32'sd76;
            zn_reg <= z2_reg * 32'sd36;
            zp_reg <= z2_reg * 32'sd45;
        end
        if (state_reg == prpz_pkg::ST_TEST)
        begin
            // quotient magnitude stays below 128 inside the window
            sx_reg   <= nx_reg[31];
            sy_reg   <= ny_reg[31];
            remx_reg <= nx_reg[31] ? 31'(-nx_reg) : nx_reg[30:0];
            remy_reg <= ny_reg[31] ? 31'(-ny_reg) : ny_reg[30:0];
            ds_reg   <= {z2_reg[19:0], 6'b000000};
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        if (state_reg == prpz_pkg::ST_DIV)
        begin
            qx_reg <= {qx_reg[5:0], bit_x};
            qy_reg <= {qy_reg[5:0], bit_y};
            if (bit_x)
            begin
                remx_reg <= remx_reg - 31'(ds_reg);
            end
            if (bit_y)
            begin
                remy_reg <= remy_reg - 31'(ds_reg);
            end
            ds_reg <= ds_reg >> 1;
        end
    end

    prpz_ram #(
        .WIDTH(prpz_pkg::WORD_W),
        .DEPTH(PIXELS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

endmodule

/* rtl/point_rotate_project_zbuffer_unit.sv */
// Words are handled one at a time by the single rotate/project/divide sequencer and its
// read-modify-write of the pixel store; the next queued word is popped only once the last
// result is pushed. A read off the window and a plot dropped at the window test skip the store.
// Reset: registers return to identity rotation, then the store is swept to
// background color and far depth, one pixel a cycle (SCREEN_WIDTH*SCREEN_HEIGHT pixels,
// 14400 by default); full stays high during the sweep.
module point_rotate_project_zbuffer_unit #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 90
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    input  prpz_pkg::req_t req,
    input  logic           push,
    output logic           full,
    output prpz_pkg::rsp_t rsp,
    output logic           empty,
    input  logic           pop
);

    prpz_pkg::rot_t rot_reg;
    prpz_pkg::cmd_t cmd;
    prpz_pkg::rsp_t res;
    logic           cmd_empty, cmd_pop, res_push, res_full, clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg.cos_yaw   <= 16'sd16384;
            rot_reg.sin_yaw   <= 16'sd0;
            rot_reg.cos_pitch <= 16'sd16384;
            rot_reg.sin_pitch <= 16'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                prpz_pkg::REG_COS_YAW:   rot_reg.cos_yaw   <= $signed(cfg_data);
                prpz_pkg::REG_SIN_YAW:   rot_reg.sin_yaw   <= $signed(cfg_data);
                prpz_pkg::REG_COS_PITCH: rot_reg.cos_pitch <= $signed(cfg_data);
                prpz_pkg::REG_SIN_PITCH: rot_reg.sin_pitch <= $signed(cfg_data);
                default:                 rot_reg.cos_yaw   <= rot_reg.cos_yaw;
            endcase
        end
    end

    prpz_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .req      (req),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop)
    );

    prpz_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rot      (rot_reg),
        .cmd      (cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res      (res),
        .res_push (res_push),
        .res_full (res_full),
        .clearing (clearing)
    );

    prpz_fifo #(
        .WIDTH($bits(prpz_pkg::rsp_t)),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .din  (res),
        .full (res_full),
        .pop  (pop),
        .dout (rsp),
        .empty(empty)
    );

endmodule

/* tb/sv/prpz_checker.sv */
`timescale 1ns / 100ps

module prpz_checker
    import prpz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  req_t        req,
    input  logic        push,
    input  logic        full,
    input  rsp_t        rsp,
    input  logic        empty,
    input  logic        pop,
    output int          errors,
    output int          pending,
    output int          words_checked,
    output int          points_kept,
    output int          pixels_lit
);

    localparam int COLS      = 160;
    localparam int ROWS      = 90;
    localparam int PIXELS    = COLS * ROWS;
    localparam longint FAR   = 131071;
    localparam longint PIV_X = 10;
    localparam longint PIV_Y = 50;
    localparam longint PIV_Z = 160;
    localparam longint CAM   = 50;
    localparam longint SCALE = 120;

    logic [2:0]  color_mem [PIXELS];
    logic [17:0] depth_mem [PIXELS];
    longint      cy, sy, cp, sp;
    rsp_t        expected_words [$];

    function automatic logic [7:0] glyph_for(input logic [2:0] c);
        case (c)
            3'd0:    return 8'd32;
            3'd1:    return 8'd46;
            3'd2:    return 8'd42;
            3'd3:    return 8'd176;
            3'd4:    return 8'd177;
            default: return 8'd219;
        endcase
    endfunction

    // Update the pixel stores for one word and return the word the block owes.
    function automatic rsp_t render_word(input req_t w);
        rsp_t   r;
        longint dx, dz, a, b, x1, dy, z2, y2, nx, ny, col, row, zd;
        int     idx;
        r = '0;
        if (w.req_type == REQ_READ) begin
            if (w.read_column < COLS && w.read_row < ROWS) begin
                idx = int'(w.read_row) * COLS + int'(w.read_column);
                r.pixel_color = color_mem[idx];
                r.pixel_glyph = glyph_for(color_mem[idx]);
                if (color_mem[idx] != 3'd0)
                    pixels_lit++;
                color_mem[idx] = 3'd0;
                depth_mem[idx] = 18'(FAR);
            end else begin
                r.pixel_glyph = 8'd32;
            end
            return r;
        end
        dx = longint'(w.point_x) - PIV_X;
        dz = longint'(w.point_z) - PIV_Z;
        a  = (dx * cy + dz * sy) >>> 10;
        b  = (dz * cy - dx * sy) >>> 10;
        x1 = PIV_X * 16 + a;
        dy = longint'(w.point_y) * 16 - PIV_Y * 16;
        z2 = PIV_Z * 16 + ((dy * sp + b * cp) >>> 14);
        y2 = PIV_Y * 16 + ((-dy * cp - b * sp) >>> 14);
        if (z2 <= 0)
            return r;
        nx = (x1 - CAM * 16) * SCALE;
        ny = (y2 - CAM * 16) * SCALE;
        if (!(nx > -76 * z2 && nx < 76 * z2 && ny > -36 * z2 && ny < 45 * z2))
            return r;
        col = nx / z2 + 80;
        row = ny / z2 + 40;
        if (col < 0 || row < 0 || col >= COLS || row >= ROWS)
            return r;
        zd  = (z2 > FAR) ? FAR : z2;
        idx = int'(row * COLS + col);
        if (longint'(depth_mem[idx]) > zd) begin
            color_mem[idx] = w.point_color;
            depth_mem[idx] = 18'(zd);
            r.plotted = 1'b1;
            points_kept++;
        end
        return r;
    endfunction

    initial begin
        errors = 0;
        pending = 0;
        words_checked = 0;
        points_kept = 0;
        pixels_lit = 0;
        for (int i = 0; i < PIXELS; i++) begin
            color_mem[i] = 3'd0;
            depth_mem[i] = 18'(FAR);
        end
    end

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            cy = 16384;
            sy = 0;
            cp = 16384;
            sp = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_COS_YAW:   cy = longint'($signed(cfg_data));
                    REG_SIN_YAW:   sy = longint'($signed(cfg_data));
                    REG_COS_PITCH: cp = longint'($signed(cfg_data));
                    REG_SIN_PITCH: sp = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word plotted=%0d color=%0d glyph=%0d",
                             $time, rsp.plotted, rsp.pixel_color, rsp.pixel_glyph);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (rsp.plotted !== want.plotted) begin
                        $display("%0t: plotted expected %0d actual %0d",
                                 $time, want.plotted, rsp.plotted);
                        errors++;
                    end
                    if (rsp.pixel_color !== want.pixel_color) begin
                        $display("%0t: pixel_color expected %0d actual %0d",
                                 $time, want.pixel_color, rsp.pixel_color);
                        errors++;
                    end
                    if (rsp.pixel_glyph !== want.pixel_glyph) begin
                        $display("%0t: pixel_glyph expected %0d actual %0d",
                                 $time, want.pixel_glyph, rsp.pixel_glyph);
                        errors++;
                    end
                end
            end
            if (push && !full)
                expected_words.push_back(render_word(req));
            pending = expected_words.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT    = 400000;
    localparam int SETTLE   = 30;
    localparam int HOLD_LEN = 400;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [1:0]     cfg_index = prpz_pkg::REG_COS_YAW;
    logic [15:0]    cfg_data = '0;
    prpz_pkg::req_t req = '0;
    logic           push = 1'b0;
    logic           full;
    prpz_pkg::rsp_t rsp;
    logic           empty;
    logic           pop = 1'b0;

    int errors, pending, words_checked, points_kept, pixels_lit;
    int cycles = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   pop_mode = 0;

    always #5 clk = ~clk;

    point_rotate_project_zbuffer_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req), .push(push), .full(full),
        .rsp(rsp), .empty(empty), .pop(pop)
    );

    prpz_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req), .push(push), .full(full),
        .rsp(rsp), .empty(empty), .pop(pop), .errors(errors),
        .pending(pending), .words_checked(words_checked),
        .points_kept(points_kept), .pixels_lit(pixels_lit)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: one long hold-off on request, otherwise a drifting stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            pop <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                pop_mode = $urandom_range(0, 2);
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic send_word(input prpz_pkg::req_t w);
        req <= w;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic idle_push(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_rotation(input int c_yaw, input int s_yaw,
                                 input int c_pitch, input int s_pitch);
        cfg_we <= 1'b1;
        cfg_index <= prpz_pkg::REG_COS_YAW;   cfg_data <= 16'(c_yaw);   @(posedge clk);
        cfg_index <= prpz_pkg::REG_SIN_YAW;   cfg_data <= 16'(s_yaw);   @(posedge clk);
        cfg_index <= prpz_pkg::REG_COS_PITCH; cfg_data <= 16'(c_pitch); @(posedge clk);
        cfg_index <= prpz_pkg::REG_SIN_PITCH; cfg_data <= 16'(s_pitch); @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic prpz_pkg::req_t plot_word(input int x, input int y, input int z,
                                                 input int c);
        prpz_pkg::req_t w;
        w = '0;
        w.req_type = prpz_pkg::REQ_PLOT;
        w.point_x = 8'(x);
        w.point_y = 8'(y);
        w.point_z = 8'(z);
        w.point_color = 3'(c);
        w.read_column = 8'($urandom);
        w.read_row = 7'($urandom);
        return w;
    endfunction

    function automatic prpz_pkg::req_t read_word(input int col, input int row);
        prpz_pkg::req_t w;
        w = '0;
        w.req_type = prpz_pkg::REQ_READ;
        w.point_x = 8'($urandom);
        w.point_y = 8'($urandom);
        w.point_z = 8'($urandom);
        w.point_color = 3'($urandom);
        w.read_column = 8'(col);
        w.read_row = 7'(row);
        return w;
    endfunction

    // Most points cluster near the screen center so reads find lit pixels.
    function automatic prpz_pkg::req_t random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return plot_word($urandom_range(35, 65), $urandom_range(35, 65),
                             $urandom_range(90, 230), $urandom_range(0, 7));
        if (pick < 65)
            return plot_word($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 7));
        if (pick < 90)
            return read_word($urandom_range(70, 90), $urandom_range(30, 50));
        if (pick < 96)
            return read_word($urandom_range(0, 159), $urandom_range(0, 89));
        return read_word($urandom_range(0, 255), $urandom_range(0, 127));
    endfunction

    task automatic random_burst(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            repeat ($urandom_range(1, 12))
            begin
                if (sent < count)
                begin
                    send_word(random_word());
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                idle_push($urandom_range(1, 25));
        end
    endtask

    initial
    begin
        int c_yaw, s_yaw, c_pitch, s_pitch;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the identity rotation.
        send_word(plot_word(50, 50, 100, 5));
        send_word(plot_word(50, 50, 90, 3));
        send_word(plot_word(50, 50, 120, 6));
        send_word(read_word(80, 40));
        send_word(read_word(80, 40));
        send_word(plot_word(50, 50, 110, 0));
        send_word(read_word(80, 40));
        send_word(plot_word(0, 0, 0, 7));
        send_word(plot_word(255, 255, 255, 7));
        send_word(plot_word(0, 0, 255, 1));
        send_word(plot_word(255, 0, 0, 2));
        send_word(plot_word(60, 60, 200, 4));
        send_word(plot_word(45, 55, 150, 1));
        send_word(plot_word(50, 20, 100, 2));
        send_word(read_word(0, 0));
        send_word(read_word(159, 89));
        send_word(read_word(160, 0));
        send_word(read_word(0, 90));
        send_word(read_word(255, 127));
        drain();

        // Receiver holds off while the sender keeps offering.
        hold_go <= 1'b1;
        random_burst(60);
        drain();

        load_rotation(-16384, 0, -16384, 0);
        random_burst(50);
        drain();
        load_rotation(0, 16384, 0, -16384);
        random_burst(50);
        drain();
        load_rotation(32767, -32768, 32767, -32768);
        random_burst(40);
        drain();
        load_rotation(-32768, 32767, -32768, 32767);
        random_burst(30);
        drain();
        repeat (4)
        begin
            c_yaw = $urandom_range(0, 32768) - 16384;
            s_yaw = $urandom_range(0, 32768) - 16384;
            c_pitch = $urandom_range(0, 32768) - 16384;
            s_pitch = $urandom_range(0, 32768) - 16384;
            load_rotation(c_yaw, s_yaw, c_pitch, s_pitch);
            random_burst(35);
            drain();
        end
        load_rotation(16384, 0, 16384, 0);
        random_burst(40);
        drain();

        $display("covered %0d words across nine rotation settings: %0d points kept,",
                 words_checked, points_kept);
        $display("%0d reads of lit pixels, with a long receiver hold-off", pixels_lit);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
